// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion, active through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/srl_pkg.sv =====
// Shared types and constants for the S-record S1 loader.
// Depends on nothing; imported by the front, queue, back and top modules of the block.
`timescale 1ns / 1ps

package srl_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_S   = 8'h53;
    localparam logic [7:0] CHAR_ONE = 8'h31;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_F   = 8'h46;
    localparam logic [7:0] COUNT_OVERHEAD = 8'd3;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
    } wr_beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== design/srl_front.sv =====
// Front end: accepts characters, runs the record parser, pushes write beats.
// Depends on srl_pkg.
`timescale 1ns / 1ps

module srl_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_char_in,
    input  srl_pkg::q_stat_t q_stat,
    output logic             push_valid,
    output srl_pkg::wr_beat_t push_beat
);
    import srl_pkg::*;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_TYPE    = 7'b0000010,
        PH_CNT_HI  = 7'b0000100,
        PH_CNT_LO  = 7'b0001000,
        PH_ADDR    = 7'b0010000,
        PH_DATA_HI = 7'b0100000,
        PH_DATA_LO = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  digit_reg, digit_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] addr_reg, addr_next;
    logic [3:0]  nib;
    logic [7:0]  count;
    logic        accept;

    function automatic logic [3:0] digit_value(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
            diff = ch - CHAR_0;
        end else if (ch >= CHAR_A && ch <= CHAR_F) begin
            diff = ch - CHAR_A + 8'd10;
        end
        return diff[3:0];
    endfunction

    assign nib     = digit_value(s_char_in);
    assign count   = {high_nibble_reg, nib};
    assign s_ready = !(phase_reg == PH_DATA_LO && q_stat.full);
    assign accept  = s_valid && s_ready;

    assign push_valid     = accept && (phase_reg == PH_DATA_LO);
    assign push_beat.addr = addr_reg;
    assign push_beat.data = {high_nibble_reg, nib};

    always_comb begin
        phase_next       = phase_reg;
        digit_next       = digit_reg;
        high_nibble_next = high_nibble_reg;
        bytes_left_next  = bytes_left_reg;
        addr_next        = addr_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    phase_next = (s_char_in == CHAR_ONE) ? PH_CNT_HI : PH_HUNT;
                end
                PH_CNT_HI: begin
                    high_nibble_next = nib;
                    phase_next       = PH_CNT_LO;
                end
                PH_CNT_LO: begin
                    bytes_left_next = (count < COUNT_OVERHEAD) ? 8'd0 : count - COUNT_OVERHEAD;
                    digit_next      = 2'd0;
                    phase_next      = PH_ADDR;
                end
                PH_ADDR: begin
                    addr_next  = {addr_reg[11:0], nib};
                    digit_next = digit_reg + 2'd1;
                    if (digit_reg == 2'd3) begin
                        phase_next = (bytes_left_reg == 8'd0) ? PH_HUNT : PH_DATA_HI;
                    end
                end
                PH_DATA_HI: begin
                    high_nibble_next = nib;
                    phase_next       = PH_DATA_LO;
                end
                PH_DATA_LO: begin
                    addr_next       = addr_reg + 16'd1;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    phase_next      = (bytes_left_reg == 8'd1) ? PH_HUNT : PH_DATA_HI;
                end
                default: begin
                    phase_next = (s_char_in == CHAR_S) ? PH_TYPE : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            digit_reg       <= 2'd0;
            high_nibble_reg <= 4'd0;
            bytes_left_reg  <= 8'd0;
            addr_reg        <= 16'd0;
        end else begin
            phase_reg       <= phase_next;
            digit_reg       <= digit_next;
            high_nibble_reg <= high_nibble_next;
            bytes_left_reg  <= bytes_left_next;
            addr_reg        <= addr_next;
        end
    end

endmodule

// ===== design/srl_queue.sv =====
// Short beat queue between the parser and the output stage.
// Depends on srl_pkg.
`timescale 1ns / 1ps

module srl_queue #(
    parameter int DEPTH = srl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  srl_pkg::wr_beat_t push_beat,
    input  logic              pop,
    output srl_pkg::wr_beat_t head_beat,
    output srl_pkg::q_stat_t  q_stat
);
    import srl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wr_beat_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push_valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_beat    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/srl_back.sv =====
// Back end: output register that drains the queue onto the write channel.
// Depends on srl_pkg.
`timescale 1ns / 1ps

module srl_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  srl_pkg::q_stat_t  q_stat,
    input  srl_pkg::wr_beat_t head_beat,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_write_address,
    output logic [7:0]        m_write_data
);
    import srl_pkg::*;

    logic     valid_reg;
    wr_beat_t beat_reg;

    assign pop             = !q_stat.empty && (!valid_reg || m_ready);
    assign m_valid         = valid_reg;
    assign m_write_address = beat_reg.addr;
    assign m_write_data    = beat_reg.data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            beat_reg <= head_beat;
        end
    end

endmodule

// ===== design/srecord_s1_loader.sv =====
// S-record S1 loader: one character per cycle in, one memory write per data byte out.
// A write beat enters the beat queue at the edge accepting its second data digit,
// then the output register behind m_valid. Throughput: one character per cycle;
// the parser stalls only on a data low digit while the QUEUE_DEPTH queue is full.
// Reset: synchronous, active-low aresetn returns the parser to hunting for 'S',
// clears address, count and the queue.
`timescale 1ns / 1ps

module srecord_s1_loader #(
    parameter int QUEUE_DEPTH = srl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_data
);
    import srl_pkg::*;

    q_stat_t  q_stat;
    wr_beat_t push_beat;
    wr_beat_t head_beat;
    logic     push_valid;
    logic     pop;

    srl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_beat  (push_beat)
    );

    srl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_beat  (push_beat),
        .pop        (pop),
        .head_beat  (head_beat),
        .q_stat     (q_stat)
    );

    srl_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .head_beat       (head_beat),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data)
    );

endmodule

// ===== design/srl_checker.sv =====
// Port-level checks for the S-record S1 loader, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_char_in,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_write_address,
    input logic [7:0]  m_write_data
);

    `ASSERT_RST(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped while stalled")
    `ASSERT_RST(a_m_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_write_address) && $stable(m_write_data), "write beat changed while stalled")
    `ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_valid, "m_valid high after reset")
    `ASSERT_RST(a_rise_src, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 2), "write beat without a character two cycles earlier")
    `ASSERT_RST(a_s_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_char_in), "character changed while stalled")

endmodule

bind srecord_s1_loader srl_checker u_srl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_char_in       (s_char_in),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_write_address (m_write_address),
    .m_write_data    (m_write_data)
);
